/* design/slfr_pkg.sv */
// ----------------------------------------------------------------------------
// slfr_pkg: shared types and constants of the sync/length frame receiver
// Configuration register indexes, the configuration bundle and the result item.
// ----------------------------------------------------------------------------
package slfr_pkg;

	// Widths fixed by the link format.
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 16;
	localparam int FLEN_W   = 32;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 32;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h12;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h34;
	localparam logic [FLEN_W-1:0] MAX_PAYLOAD_RST = 32'd1048576;

	// Current configuration, as seen by the deframer.
	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [FLEN_W-1:0] max_payload;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              last;
		logic [KIND_W-1:0] msg_kind;
		logic [FLEN_W-1:0] frame_length;
	} res_t;

endpackage

/* design/slfr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// slfr_cfg_regs: configuration registers
// Holds the sync bytes and the payload limit; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module slfr_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [slfr_pkg::CIDX_W-1:0]       wr_index,
	input  logic [slfr_pkg::CDATA_W-1:0]      wr_data,
	output slfr_pkg::cfg_t                    cfg
);

	slfr_pkg::cfg_t cfg_q;

	// Register write decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= slfr_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second <= slfr_pkg::SYNC_SECOND_RST;
			cfg_q.max_payload <= slfr_pkg::MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				slfr_pkg::CFG_SYNC_FIRST: begin
					cfg_q.sync_first <= wr_data[slfr_pkg::BYTE_W-1:0];
				end
				slfr_pkg::CFG_SYNC_SECOND: begin
					cfg_q.sync_second <= wr_data[slfr_pkg::BYTE_W-1:0];
				end
				slfr_pkg::CFG_MAX_PAYLOAD: begin
					cfg_q.max_payload <= wr_data[slfr_pkg::FLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/slfr_deframer.sv */
// ----------------------------------------------------------------------------
// slfr_deframer: frame parser and result register
// Tracks the frame phase byte by byte and registers at most one result per item.
// ----------------------------------------------------------------------------
module slfr_deframer #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slfr_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	input  logic [slfr_pkg::BYTE_W-1:0]  in_byte,
	output logic                         in_take,
	output logic                         res_valid,
	input  logic                         res_ready,
	output slfr_pkg::res_t               res
);

	localparam int LEN_BYTES = (LENGTH_BITS + 7) / 8;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_TYPE,
		PH_SIZE,
		PH_PAYLOAD
	} phase_t;

	phase_t                               phase_q, phase_d;
	logic [LENGTH_BITS-1:0]               cnt_q, cnt_d;
	logic [slfr_pkg::KIND_W-1:0]          kind_q, kind_d;
	logic [LENGTH_BITS-1:0]               len_q, len_d;
	logic [LENGTH_BITS-1:0]               len_shift;
	logic [LENGTH_BITS-1:0]               cnt_inc;
	logic                                 emit;
	logic [slfr_pkg::BYTE_W-1:0]          emit_byte;
	logic                                 emit_bvalid;
	logic                                 emit_last;
	logic                                 res_valid_q;
	slfr_pkg::res_t                       res_q;

	// The input item moves on whenever the result register is free or draining.
	assign in_take   = in_valid && (!res_valid_q || res_ready);
	assign len_shift = LENGTH_BITS'({len_q, in_byte});
	assign cnt_inc   = cnt_q + LENGTH_BITS'(1);

	// Next phase, counters and result for the item at the input.
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		kind_d      = kind_q;
		len_d       = len_q;
		emit        = 1'b0;
		emit_byte   = in_byte;
		emit_bvalid = 1'b1;
		emit_last   = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				len_d = '0;
				cnt_d = '0;
				if (in_byte == cfg.sync_first) begin
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				cnt_d = '0;
				if (in_byte == cfg.sync_second) begin
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_TYPE: begin
				if (cnt_q == '0) begin
					kind_d = {{(slfr_pkg::KIND_W - slfr_pkg::BYTE_W){1'b0}}, in_byte};
					cnt_d  = LENGTH_BITS'(1);
				end else begin
					kind_d  = {in_byte, kind_q[slfr_pkg::BYTE_W-1:0]};
					phase_d = PH_SIZE;
					cnt_d   = '0;
					len_d   = '0;
				end
			end
			PH_SIZE: begin
				len_d = len_shift;
				cnt_d = cnt_inc;
				if (cnt_q == LENGTH_BITS'(LEN_BYTES - 1)) begin
					cnt_d = '0;
					if (len_shift == '0) begin
						// Empty message: one result that closes the frame.
						emit        = 1'b1;
						emit_byte   = '0;
						emit_bvalid = 1'b0;
						emit_last   = 1'b1;
						phase_d     = PH_HUNT;
					end else if (slfr_pkg::FLEN_W'(len_shift) > cfg.max_payload) begin
						// Oversized frame is dropped without a result.
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				emit  = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc == len_q) begin
					emit_last = 1'b1;
					phase_d   = PH_HUNT;
					cnt_d     = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				cnt_d   = '0;
			end
		endcase
	end

	// Frame state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cnt_q       <= '0;
			kind_q      <= '0;
			len_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (in_take) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				kind_q  <= kind_d;
				len_q   <= len_d;
			end
			// A new result refills the register in the cycle the old one drains.
			if (in_take && emit) begin
				res_valid_q        <= 1'b1;
				res_q.out_byte     <= emit_byte;
				res_q.byte_valid   <= emit_bvalid;
				res_q.last         <= emit_last;
				res_q.msg_kind     <= kind_d;
				res_q.frame_length <= slfr_pkg::FLEN_W'(len_d);
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* design/sync_length_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_receiver: sync word and length prefixed frame receiver
// Hunts for two sync bytes, reads type and length, then streams payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready, rx_byte) takes one link byte per
//   item. The output channel (out_valid/out_ready) gives one result item per
//   payload byte, with the message type and announced length; the final byte
//   carries last. A zero length gives a single item with byte_valid low and
//   last high. Frames longer than max_payload are dropped without any item.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready and writes sync_first, sync_second or max_payload; write it
//   only while the block is idle.
//   A byte accepted at the input sits in the input register until the
//   deframer takes it, and its result is then registered in the result
//   register that drives out_valid. Throughput is one item per cycle while
//   out_ready stays high; the deframer updates its phase once per byte.
//   Reset clears the configuration to 0x12, 0x34 and 1 MiB and puts the block
//   in the hunting phase with no item pending. When the receiver stalls, the
//   result register holds and at most one more byte waits in the input
//   register; in_ready then stays low until the result is taken.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [slfr_pkg::BYTE_W-1:0]       rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [slfr_pkg::BYTE_W-1:0]       out_byte,
	output logic                              byte_valid,
	output logic                              last,
	output logic [slfr_pkg::KIND_W-1:0]       msg_kind,
	output logic [slfr_pkg::FLEN_W-1:0]       frame_length,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [slfr_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [slfr_pkg::CDATA_W-1:0]      cfg_data
);

	slfr_pkg::cfg_t                  cfg;
	slfr_pkg::res_t                  res;
	logic                            valid_s1;
	logic [slfr_pkg::BYTE_W-1:0]     byte_s1;
	logic                            take;

	assign cfg_ready = 1'b1;

	slfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: refills in the same cycle that its item moves on.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	slfr_deframer #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (valid_s1),
		.in_byte   (byte_s1),
		.in_take   (take),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign out_byte     = res.out_byte;
	assign byte_valid   = res.byte_valid;
	assign last         = res.last;
	assign msg_kind     = res.msg_kind;
	assign frame_length = res.frame_length;

endmodule

/* design/slfr_checker.sv */
// ----------------------------------------------------------------------------
// slfr_checker: port-level checks of the frame receiver
// Watches the top-level ports and flags result items that break the framing rules.
// ----------------------------------------------------------------------------
module slfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [slfr_pkg::BYTE_W-1:0]   out_byte,
	input logic                          byte_valid,
	input logic                          last,
	input logic [slfr_pkg::FLEN_W-1:0]   frame_length
);

	// An empty-message item is a zero byte that closes a zero-length frame.
	a_empty_msg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last && out_byte == '0 && frame_length == '0)
		else $error("empty message item is malformed");

	// A payload item always belongs to a frame with a nonzero length.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> frame_length != '0)
		else $error("payload item with zero frame length");

	// A one-byte frame ends on its only payload item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid && frame_length == 32'd1 |-> last)
		else $error("one-byte frame not marked last");

	// With the result register empty, the input side never stalls.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending result");

	// A stalled result item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled result item changed");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.byte_valid   (byte_valid),
	.last         (last),
	.frame_length (frame_length)
);
